// ----- hw/rtl/bf3_pkg.sv -----
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int SAMPLE_W = 8;
    localparam int PIX_W    = 3 * SAMPLE_W;
    localparam int SUM_W    = 12;              // 9 * 255 = 2295
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_LW     = $clog2(Q_DEPTH + 1);

    // floor(s/9) == (s * 7282) >> 16 for every s below 2296
    localparam logic [13:0] RECIP9 = 14'd7282;

    localparam logic [11:0] FW_RESET = 12'd640;
    localparam logic [15:0] FH_RESET = 16'd480;

    localparam logic REG_FW = 1'b0;
    localparam logic REG_FH = 1'b1;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] K_PUSH  = 2'd0;
    localparam logic [1:0] K_DRAIN = 2'd1;
    localparam logic [1:0] K_PRIME = 2'd2;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    typedef struct packed {
        logic [1:0] kind;
        logic       first;   // column zero of a row
        logic       e1;      // emits the pixel up-left
        logic       e2;      // emits the row's last pixel too
        logic       fend;    // last drain of the frame
        t_col       col;
    } t_job;

endpackage

// ----- hw/rtl/bf3_in_if.sv -----
// ----------------------------------------------------------------------------
// bf3_in_if
// Input pixel channel: opcode and RGB samples.
// ----------------------------------------------------------------------------
interface bf3_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output opcode, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input opcode, input red, input green, input blue,
                    output ready);
endinterface

// ----- hw/rtl/bf3_out_if.sv -----
// ----------------------------------------------------------------------------
// bf3_out_if
// Result channel: filtered RGB pixel and framing flags.
// ----------------------------------------------------------------------------
interface bf3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_mean;
    logic [7:0] green_mean;
    logic [7:0] blue_mean;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output red_mean, output green_mean, output blue_mean,
                    output run_last, output frame_end, input ready);
    modport sink   (input valid, input red_mean, input green_mean, input blue_mean,
                    input run_last, input frame_end, output ready);
endinterface

// ----- hw/rtl/bf3_ram.sv -----
// ----------------------------------------------------------------------------
// bf3_ram
// Simple dual-port RAM, one write and one registered read, read-first.
// ----------------------------------------------------------------------------
module bf3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/bf3_front.sv -----
// ----------------------------------------------------------------------------
// bf3_front
// Accepts pixels and drains, tracks row/column, runs the line stores and
// queues a column job per push or live drain, plus a priming job.
// ----------------------------------------------------------------------------
module bf3_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    bf3_in_if.sink                  i_pix,
    input  logic [11:0]             i_fw,
    input  logic [15:0]             i_fh,
    input  logic                    i_cfg_wr,
    input  logic [bf3_pkg::Q_LW-1:0] i_level,
    output logic                    o_job_v,
    output bf3_pkg::t_job           o_job
);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int Q_LW_P1 = bf3_pkg::Q_LW + 1;

    logic [15:0]   w_last16;
    logic [CW-1:0] w_last;
    logic [15:0]   h_eff;

    logic [15:0]   r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_drain, n_drain;
    logic          r_primed, n_primed;

    logic          is_push, push_rst, drain_live, need_prime, space;
    logic          acc, prime_go, issue;
    logic [CW-1:0] x;
    logic [15:0]   y;
    logic [CW-1:0] rd_addr;

    // stage 1: RAM data returns
    logic          r_s1_v;
    logic [1:0]    r_s1_kind;
    logic          r_s1_first, r_s1_e1, r_s1_e2, r_s1_fend, r_s1_upper;
    bf3_pkg::t_pix r_s1_pix;
    logic [CW-1:0] r_s1_addr;

    logic          r_fw_v;
    logic [CW-1:0] r_fw_addr;
    bf3_pkg::t_pix r_fw_data;

    bf3_pkg::t_pix mid_q, upper_q, upper_fwd, pix_in;
    logic          up_we;

    always_comb begin
        if (i_fw == 12'd0) begin
            w_last16 = 16'd0;
        end else if ({4'b0, i_fw} > 16'(MAX_WIDTH)) begin
            w_last16 = 16'(MAX_WIDTH - 1);
        end else begin
            w_last16 = {4'b0, i_fw} - 16'd1;
        end
    end
    assign w_last = w_last16[CW-1:0];
    assign h_eff  = (i_fh == 16'd0) ? 16'd1 : i_fh;

    assign is_push    = (i_pix.opcode == bf3_pkg::OP_PUSH);
    assign push_rst   = (r_row >= h_eff) || (16'(r_col) > w_last16);
    assign x          = push_rst ? '0 : r_col;
    assign y          = push_rst ? 16'd0 : r_row;
    assign drain_live = (r_row >= h_eff) && (16'(r_drain) <= w_last16);
    assign need_prime = drain_live && (r_drain == '0) && !r_primed;
    assign space      = ({1'b0, i_level} + (Q_LW_P1)'(r_s1_v)) < (Q_LW_P1)'(bf3_pkg::Q_DEPTH);

    assign i_pix.ready = space && !(!is_push && need_prime);
    assign acc         = i_pix.valid && i_pix.ready;
    assign prime_go    = i_pix.valid && !is_push && need_prime && space;
    assign issue       = (acc && (is_push || drain_live)) || prime_go;
    assign pix_in      = {i_pix.red, i_pix.green, i_pix.blue};

    always_comb begin
        if (is_push) begin
            rd_addr = x;
        end else if (need_prime || r_drain == w_last) begin
            rd_addr = r_drain;
        end else begin
            rd_addr = r_drain + 1'b1;
        end
    end

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_drain  = r_drain;
        n_primed = r_primed;
        if (i_cfg_wr) begin
            n_row    = 16'd0;
            n_col    = '0;
            n_drain  = '0;
            n_primed = 1'b0;
        end else if (acc && is_push) begin
            n_primed = 1'b0;
            n_drain  = push_rst ? '0 : r_drain;
            if (x == w_last) begin
                n_col = '0;
                n_row = y + 16'd1;
            end else begin
                n_col = x + 1'b1;
                n_row = y;
            end
        end else if (prime_go) begin
            n_primed = 1'b1;
        end else if (acc && drain_live) begin
            if (r_drain == w_last) begin
                n_row    = 16'd0;
                n_col    = '0;
                n_drain  = '0;
                n_primed = 1'b0;
            end else begin
                n_drain = r_drain + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= 16'd0;
            r_col    <= '0;
            r_drain  <= '0;
            r_primed <= 1'b0;
            r_s1_v   <= 1'b0;
            r_fw_v   <= 1'b0;
        end else begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_drain  <= n_drain;
            r_primed <= n_primed;
            r_s1_v   <= issue;
            r_fw_v   <= up_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_kind  <= is_push ? bf3_pkg::K_PUSH :
                          (prime_go ? bf3_pkg::K_PRIME : bf3_pkg::K_DRAIN);
            r_s1_first <= (x == '0);
            r_s1_e1    <= (y != 16'd0) && (x != '0);
            r_s1_e2    <= (y != 16'd0) && (x == w_last);
            r_s1_fend  <= (r_drain == w_last);
            r_s1_upper <= is_push ? (y >= 16'd2) : (h_eff >= 16'd2);
            r_s1_pix   <= pix_in;
            r_s1_addr  <= rd_addr;
        end
        r_fw_addr <= r_s1_addr;
        r_fw_data <= mid_q;
    end

    // the upper store takes the middle store's old entry in the following cycle
    assign up_we     = r_s1_v && (r_s1_kind == bf3_pkg::K_PUSH);
    assign upper_fwd = (r_fw_v && r_fw_addr == r_s1_addr) ? r_fw_data : upper_q;

    bf3_ram #(.WIDTH(bf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (acc && is_push),
        .i_waddr (x),
        .i_wdata (pix_in),
        .i_raddr (rd_addr),
        .o_rdata (mid_q)
    );

    bf3_ram #(.WIDTH(bf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (up_we),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_q),
        .i_raddr (rd_addr),
        .o_rdata (upper_q)
    );

    assign o_job_v         = r_s1_v;
    assign o_job.kind      = r_s1_kind;
    assign o_job.first     = r_s1_first;
    assign o_job.e1        = r_s1_e1;
    assign o_job.e2        = r_s1_e2;
    assign o_job.fend      = r_s1_fend;
    assign o_job.col.top   = r_s1_upper ? upper_fwd : mid_q;
    assign o_job.col.mid   = mid_q;
    assign o_job.col.bot   = (r_s1_kind == bf3_pkg::K_PUSH) ? r_s1_pix : mid_q;

endmodule

// ----- hw/rtl/bf3_queue.sv -----
// ----------------------------------------------------------------------------
// bf3_queue
// Short FIFO of column jobs between front and back.
// ----------------------------------------------------------------------------
module bf3_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  bf3_pkg::t_job            i_job,
    input  logic                     i_pop,
    output logic                     o_head_v,
    output bf3_pkg::t_job            o_head,
    output logic [bf3_pkg::Q_LW-1:0] o_level
);
    bf3_pkg::t_job              r_mem [bf3_pkg::Q_DEPTH];
    logic [bf3_pkg::Q_AW-1:0]   r_wp, r_rp;
    logic [bf3_pkg::Q_LW-1:0]   r_cnt, n_cnt;
    logic                       pop;

    assign pop      = i_pop && (r_cnt != '0);
    assign o_head_v = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];
    assign o_level  = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != bf3_pkg::Q_LW'(bf3_pkg::Q_DEPTH)) || pop)
        else $error("job queue overflow");

endmodule

// ----- hw/rtl/bf3_back.sv -----
// ----------------------------------------------------------------------------
// bf3_back
// Window registers, 9-sample sums and divide by nine; drives the result
// channel through a sum stage and an output register.
// ----------------------------------------------------------------------------
module bf3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_v,
    input  bf3_pkg::t_job i_head,
    output logic          o_pop,
    bf3_out_if.source     o_res
);
    localparam int SW = bf3_pkg::SUM_W;

    bf3_pkg::t_col [2:0] r_win, n_win;   // index 0 is the left column
    logic                r_phase, n_phase;
    logic                take, emit, last;

    logic                r_sum_v;
    logic [SW-1:0]       r_sum [3];
    logic                r_sum_last, r_sum_fend;
    logic [SW-1:0]       sum [3];

    logic                r_out_v;
    logic [7:0]          r_out [3];
    logic                r_out_last, r_out_fend;
    logic [SW+13:0]      prod [3];

    logic out_free, sum_free, is_push, both;

    assign out_free = !r_out_v || o_res.ready;
    assign sum_free = !r_sum_v || out_free;
    assign take     = sum_free && i_head_v;
    assign is_push  = (i_head.kind == bf3_pkg::K_PUSH);
    assign both     = i_head.e1 && i_head.e2;

    always_comb begin
        n_win   = r_win;
        n_phase = r_phase;
        emit    = 1'b0;
        last    = 1'b1;
        o_pop   = 1'b0;
        if (take) begin
            o_pop = 1'b1;
            if (i_head.kind == bf3_pkg::K_PRIME || (is_push && !r_phase && i_head.first)) begin
                n_win[0] = i_head.col;
                n_win[1] = i_head.col;
                n_win[2] = i_head.col;
            end else begin
                n_win[0] = r_win[1];
                n_win[1] = r_win[2];
                n_win[2] = i_head.col;
            end
            if (i_head.kind == bf3_pkg::K_DRAIN) begin
                emit = 1'b1;
            end else if (is_push) begin
                if (r_phase) begin
                    emit    = 1'b1;
                    n_phase = 1'b0;
                end else begin
                    emit = i_head.e1 || i_head.e2;
                    if (both) begin
                        last    = 1'b0;
                        o_pop   = 1'b0;
                        n_phase = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int c = 0; c < 3; c++) begin
                sum[ch] = sum[ch]
                    + SW'(n_win[c].top[(2-ch)*bf3_pkg::SAMPLE_W +: bf3_pkg::SAMPLE_W])
                    + SW'(n_win[c].mid[(2-ch)*bf3_pkg::SAMPLE_W +: bf3_pkg::SAMPLE_W])
                    + SW'(n_win[c].bot[(2-ch)*bf3_pkg::SAMPLE_W +: bf3_pkg::SAMPLE_W]);
            end
            prod[ch] = (SW+14)'(r_sum[ch]) * (SW+14)'(bf3_pkg::RECIP9);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_phase <= 1'b0;
            r_sum_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_win   <= n_win;
            r_phase <= n_phase;
            if (sum_free) begin
                r_sum_v <= emit;
            end
            if (out_free) begin
                r_out_v <= r_sum_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_free && emit) begin
            r_sum      <= sum;
            r_sum_last <= last;
            r_sum_fend <= (i_head.kind == bf3_pkg::K_DRAIN) && i_head.fend;
        end
        if (out_free && r_sum_v) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out[ch] <= prod[ch][23:16];
            end
            r_out_last <= r_sum_last;
            r_out_fend <= r_sum_fend;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.red_mean   = r_out[0];
    assign o_res.green_mean = r_out[1];
    assign o_res.blue_mean  = r_out[2];
    assign o_res.run_last   = r_out_last;
    assign o_res.frame_end  = r_out_fend;

    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_fend |-> r_out_last)
        else $error("frame end without run last");

    a_phase_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_head_v && i_head.kind == bf3_pkg::K_PUSH)
        else $error("second result pending without its push");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_v |-> r_sum[0] <= SW'(2295) && r_sum[1] <= SW'(2295) && r_sum[2] <= SW'(2295))
        else $error("window sum out of range");

endmodule

// ----- hw/rtl/box_filter_3x3_replicate.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_replicate
// 3x3 mean filter over RGB raster pixels with replicated borders.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one transaction per pixel (opcode push) or per drain
//   (opcode drain). o_res returns the truncated 3x3 means, run_last on the
//   final result of each input transaction and frame_end on the last pixel
//   of the frame. A push in row y>0 returns pixel (y-1,x-1), plus
//   (y-1,W-1) at the row's last column; the last row comes out one pixel
//   per drain. Frame width and height are written over the APB port while
//   the block is idle (a user rule, unenforced); a write restarts the frame.
// Rate: one transaction per cycle while the job queue has space. The first
//   drain of a frame waits for a priming job that fetches its left column;
//   a push giving two results holds the back end until both are out. Jobs
//   pass a front-end register, the job queue, the sum stage and the output
//   register. Line stores: single-write dual-port RAMs, one read per cycle.
// Reset: counters, window and pipeline valids clear; the line stores are
//   not cleared and need no clearing pass. When o_res stalls, the output
//   register, the sum stage and the four-entry job queue fill, then
//   i_pix.ready drops.
// ----------------------------------------------------------------------------
module box_filter_3x3_replicate #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bf3_in_if.sink      i_pix,
    bf3_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [11:0] r_fw;
    logic [15:0] r_fh;
    logic        cfg_wr;

    logic                     job_v, pop, head_v;
    bf3_pkg::t_job            job, head;
    logic [bf3_pkg::Q_LW-1:0] level;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == bf3_pkg::REG_FH) ? {16'd0, r_fh} : {20'd0, r_fw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= bf3_pkg::FW_RESET;
            r_fh <= bf3_pkg::FH_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == bf3_pkg::REG_FW) begin
                r_fw <= pwdata[11:0];
            end else begin
                r_fh <= pwdata[15:0];
            end
        end
    end

    bf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_fw     (r_fw),
        .i_fh     (r_fh),
        .i_cfg_wr (cfg_wr),
        .i_level  (level),
        .o_job_v  (job_v),
        .o_job    (job)
    );

    bf3_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (job_v),
        .i_job    (job),
        .i_pop    (pop),
        .o_head_v (head_v),
        .o_head   (head),
        .o_level  (level)
    );

    bf3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head_v (head_v),
        .i_head   (head),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

// ----- dv/bf3_checker.sv -----
// ----------------------------------------------------------------------------
// bf3_checker
// Watches the pixel, result and APB ports of the 3x3 box filter, predicts the
// filtered pixels from its own copy of the line stores and window, and
// compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module bf3_checker #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bf3_in_if           pix,
    bf3_out_if          res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red_mean;
        logic [7:0] green_mean;
        logic [7:0] blue_mean;
        logic       run_last;
        logic       frame_end;
    } t_mean_px;

    t_mean_px      mean_q[$];
    logic [11:0]   cfg_width;
    logic [15:0]   cfg_height;
    bf3_pkg::t_pix upper_st[MAX_WIDTH];
    bf3_pkg::t_pix middle_st[MAX_WIDTH];
    bf3_pkg::t_pix win[9];          // column*3 + row, column 0 left, row 0 top
    int unsigned   rows;
    int unsigned   cols;
    int unsigned   drains;

    assign o_pending = mean_q.size();

    initial begin
        o_errors = 0;
        foreach (win[i]) win[i] = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_st[i]  = '0;
            middle_st[i] = '0;
        end
    end

    function automatic int unsigned width_eff();
        int unsigned w;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned height_eff();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic t_mean_px box_mean(input bf3_pkg::t_pix px[9], input logic fend);
        logic [bf3_pkg::SUM_W-1:0] sr, sg, sb;
        t_mean_px m;
        sr = '0; sg = '0; sb = '0;
        for (int i = 0; i < 9; i++) begin
            sr += bf3_pkg::SUM_W'(px[i][23:16]);
            sg += bf3_pkg::SUM_W'(px[i][15:8]);
            sb += bf3_pkg::SUM_W'(px[i][7:0]);
        end
        m.red_mean   = 8'(sr / 9);
        m.green_mean = 8'(sg / 9);
        m.blue_mean  = 8'(sb / 9);
        m.run_last   = 1'b0;
        m.frame_end  = fend;
        return m;
    endfunction

    function automatic void shift_win(input bf3_pkg::t_pix top, input bf3_pkg::t_pix mid,
                                      input bf3_pkg::t_pix bot);
        for (int i = 0; i < 6; i++) win[i] = win[i+3];
        win[6] = top;
        win[7] = mid;
        win[8] = bot;
    endfunction

    function automatic void predict_push(input bf3_pkg::t_pix p);
        int unsigned w, h, x, y;
        bf3_pkg::t_pix top, mid;
        t_mean_px got[$];
        w = width_eff();
        h = height_eff();
        if (rows >= h || cols >= w) begin
            rows = 0; cols = 0; drains = 0;
        end
        x = cols;
        y = rows;
        mid = middle_st[x];
        top = (y >= 2) ? upper_st[x] : mid;
        upper_st[x]  = mid;
        middle_st[x] = p;
        if (x == 0) begin
            for (int c = 0; c < 3; c++) begin
                win[c*3]   = top;
                win[c*3+1] = mid;
                win[c*3+2] = p;
            end
        end else begin
            shift_win(top, mid, p);
        end
        if (y >= 1) begin
            if (x >= 1) got.push_back(box_mean(win, 1'b0));
            if (x == w - 1) begin
                // right border: replicate the last column once more
                if (x >= 1) shift_win(top, mid, p);
                got.push_back(box_mean(win, 1'b0));
            end
        end
        if (got.size() > 0) got[got.size()-1].run_last = 1'b1;
        foreach (got[i]) mean_q.push_back(got[i]);
        if (x + 1 >= w) begin
            cols = 0;
            rows = y + 1;
        end else begin
            cols = x + 1;
        end
    endfunction

    function automatic void predict_drain();
        int unsigned w, h, c, cl, cr;
        bf3_pkg::t_pix px[9];
        t_mean_px m;
        logic last;
        w = width_eff();
        h = height_eff();
        if (rows < h || drains >= w) return;     // rows missing: nothing to flush
        c  = drains;
        cl = (c == 0) ? 0 : c - 1;
        cr = (c + 1 < w) ? c + 1 : w - 1;
        px[0] = (h >= 2) ? upper_st[cl] : middle_st[cl];
        px[3] = (h >= 2) ? upper_st[c]  : middle_st[c];
        px[6] = (h >= 2) ? upper_st[cr] : middle_st[cr];
        px[1] = middle_st[cl]; px[2] = middle_st[cl];
        px[4] = middle_st[c];  px[5] = middle_st[c];
        px[7] = middle_st[cr]; px[8] = middle_st[cr];
        last = (c == w - 1);
        m = box_mean(px, last);
        m.run_last = 1'b1;
        mean_q.push_back(m);
        if (last) begin
            rows = 0; cols = 0; drains = 0;
        end else begin
            drains = c + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_mean_px act, exp_px;
        if (!i_rst_n) begin
            cfg_width  <= bf3_pkg::FW_RESET;
            cfg_height <= bf3_pkg::FH_RESET;
            rows = 0; cols = 0; drains = 0;
            foreach (win[i]) win[i] = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == bf3_pkg::REG_FW) cfg_width <= pwdata[11:0];
                else cfg_height <= pwdata[15:0];
                rows = 0; cols = 0; drains = 0;
            end
            if (pix.valid && pix.ready) begin
                if (pix.opcode == bf3_pkg::OP_PUSH) begin
                    predict_push({pix.red, pix.green, pix.blue});
                end else begin
                    predict_drain();
                end
            end
            if (res.valid && res.ready) begin
                act = {res.red_mean, res.green_mean, res.blue_mean,
                       res.run_last, res.frame_end};
                if (mean_q.size() == 0) begin
                    $display("%t: unexpected result r=%h g=%h b=%h last=%b fend=%b", $time,
                             act.red_mean, act.green_mean, act.blue_mean,
                             act.run_last, act.frame_end);
                    o_errors++;
                end else begin
                    exp_px = mean_q.pop_front();
                    if (act !== exp_px) begin
                        $display({"%t: expected r=%h g=%h b=%h last=%b fend=%b,",
                                  " got r=%h g=%h b=%h last=%b fend=%b"},
                                 $time, exp_px.red_mean, exp_px.green_mean, exp_px.blue_mean,
                                 exp_px.run_last, exp_px.frame_end, act.red_mean,
                                 act.green_mean, act.blue_mean, act.run_last, act.frame_end);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives frames, drains and register writes into the 3x3 box filter with
// random gaps and stalls on both channels; bf3_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 4000;
    localparam int DRAIN_WAIT = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          items_sent;
    int          idle_cycles;
    bit          tx_burst;
    bit          rx_burst;
    bit          hold_req;

    bf3_in_if  pix_ch();
    bf3_out_if res_ch();

    always #10 i_clk = ~i_clk;

    box_filter_3x3_replicate DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch.sink),
        .o_res  (res_ch.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    bf3_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .pix      (pix_ch),
        .res      (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .o_errors (errors),
        .o_pending(pending)
    );

    // watchdog: no transaction for too long ends the run
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("box_filter_3x3_replicate: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result receiver
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                @(negedge i_clk) res_ch.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                @(negedge i_clk) res_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            @(negedge i_clk) pix_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix_ch.valid  = 1'b1;
        pix_ch.opcode = op;
        pix_ch.red    = r;
        pix_ch.green  = g;
        pix_ch.blue   = b;
        do @(posedge i_clk); while (!pix_ch.ready);
        items_sent++;
    endtask

    task automatic push_px();
        send_item(bf3_pkg::OP_PUSH, rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic drain_px();
        send_item(bf3_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // waits out every pending result plus the pipeline depth
    task automatic wait_idle();
        @(negedge i_clk) pix_ch.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic regsel, input logic [31:0] data);
        wait_idle();
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {regsel, 2'b00};
        pwdata  = data;
        @(negedge i_clk) penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_frame(input int w, input int h);
        apb_write(bf3_pkg::REG_FW, 32'(w));
        apb_write(bf3_pkg::REG_FH, 32'(h));
    endtask

    // full frame: w*h pushes then w drains of the last row
    task automatic send_frame(input int w, input int h);
        for (int i = 0; i < w * h; i++) push_px();
        for (int i = 0; i < w; i++) drain_px();
    endtask

    initial begin
        int w, h, n;
        pix_ch.valid  = 1'b0;
        pix_ch.opcode = bf3_pkg::OP_PUSH;
        pix_ch.red    = '0;
        pix_ch.green  = '0;
        pix_ch.blue   = '0;
        idle_cycles   = 0;
        items_sent    = 0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        hold_req      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: 3x3 frame with extreme samples, early drain, restart on push
        set_frame(3, 3);
        send_item(bf3_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(bf3_pkg::OP_PUSH, 8'hff, 8'hff, 8'hff);
        send_item(bf3_pkg::OP_PUSH, 8'h00, 8'h00, 8'h00);
        send_item(bf3_pkg::OP_PUSH, 8'hff, 8'h00, 8'hff);
        for (int i = 0; i < 6; i++) push_px();
        drain_px();
        push_px();                       // abandons the pending drains
        set_frame(1, 1);
        push_px();
        drain_px();
        set_frame(0, 0);                 // both act as 1
        push_px();
        drain_px();
        set_frame(2, 1);
        send_frame(2, 1);
        set_frame(1, 4);
        send_frame(1, 4);

        // extremes of the registers
        set_frame(4095, 1);              // clamps to the widest row
        for (int i = 0; i < 6; i++) push_px();
        drain_px();                      // row not complete yet
        set_frame(2, 65535);
        for (int i = 0; i < 12; i++) push_px();
        drain_px();                      // rows still missing
        set_frame(640, 480);

        // receiver holds off while the sender streams a frame
        set_frame(20, 4);
        tx_burst = 1'b1;
        hold_req = 1'b1;
        send_frame(20, 4);
        tx_burst = 1'b0;
        wait_idle();

        n = items_sent;
        while (items_sent - n < 1700) begin
            if ($urandom_range(0, 3) != 0) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
                h = $urandom_range(1, 5);
                set_frame(w, h);
            end else begin
                wait_idle();
                w = u_checker_width();
                h = u_checker_height();
            end
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    // truncated frame followed by noise drains
                    for (int i = 0; i < $urandom_range(0, w * h); i++) push_px();
                    repeat ($urandom_range(1, 3)) drain_px();
                end
                1: begin
                    for (int i = 0; i < w * h; i++) push_px();
                    repeat ($urandom_range(0, w)) drain_px();
                    push_px();
                end
                default: send_frame(w, h);
            endcase
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        wait_idle();
        if (errors == 0) begin
            $display("box_filter_3x3_replicate: match");
        end else begin
            $display("box_filter_3x3_replicate: mismatch");
        end
        $finish;
    end

    // effective frame size currently programmed, as the checker sees it
    function automatic int u_checker_width();
        return u_checker.width_eff();
    endfunction

    function automatic int u_checker_height();
        return u_checker.height_eff();
    endfunction

endmodule
